// File: src/cgag_pkg.sv
// ----------------------------------------------------------------------------
// cgag_pkg: shared types and constants of the checkerboard grid arc generator
// Item formats, register indexes and field widths used by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cgag_pkg;

    localparam int CFG_W     = 13;   // configuration register width
    localparam int GREY_W    = 8;
    localparam int ROW_W     = 16;   // row counter wraps at 16 bits
    localparam int COL_W     = 13;   // column wraps to zero at the effective width
    localparam int POS_W     = 24;   // pixel position counter
    localparam int KEPT_W    = 26;   // kept pixel count, width times rows, one row fewer if both are odd
    localparam int NODE_W    = 25;
    localparam int LPOS_W    = 26;   // grid position modulo what a node number needs
    localparam int JOB_DEPTH = 8;
    localparam int JOB_CNT_W = 4;
    localparam int OUT_DEPTH = 2;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    typedef enum logic
    {
        REG_IMAGE_WIDTH = 1'b0,
        REG_IMAGE_ROWS  = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [GREY_W-1:0] grey;
        logic              start_of_image;
    } pixel_t;

    typedef struct packed
    {
        logic [NODE_W-1:0] tail_node;
        logic [NODE_W-1:0] head_node;
        logic [GREY_W-1:0] cost;
        logic              last_arc;
        logic              image_done;
    } arc_t;

    // One kept pixel that causes at least one arc.
    typedef struct packed
    {
        logic [GREY_W-1:0] grey;
        logic [GREY_W-1:0] left_grey;
        logic [GREY_W-1:0] up_grey;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              has_left;
        logic              has_up;
        logic              done;
    } job_t;

    // Effective geometry derived from the configuration registers.
    typedef struct packed
    {
        logic [CFG_W-1:0]  width;
        logic [KEPT_W-1:0] kept;
    } cfg_t;

endpackage

`default_nettype wire

// File: src/cgag_fifo.sv
// ----------------------------------------------------------------------------
// cgag_fifo: small synchronous queue
// Register-based first-in first-out buffer with an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module cgag_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic [WIDTH-1:0]               wdata,
    output logic                                full,
    input  wire logic                           pop,
    output logic [WIDTH-1:0]                    rdata,
    output logic                                empty,
    output logic [$clog2(DEPTH+1)-1:0]          count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: src/cgag_regs.sv
// ----------------------------------------------------------------------------
// cgag_regs: configuration registers
// APB-style register port holding image width and row count, plus the
// clamped geometry and the kept pixel count derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

module cgag_regs
    import cgag_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_ROWS  = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    localparam int          LIM_W = CFG_W + 4;
    localparam logic [LIM_W-1:0] MAX_W = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] MAX_R = LIM_W'(MAX_ROWS);

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  w_eff_reg;
    logic [CFG_W-1:0]  n_eff_reg;
    logic [KEPT_W-1:0] kept_reg;
    logic [KEPT_W-1:0] kept_next;
    logic [CFG_W-1:0]  n_trim;
    logic [CFG_W-1:0]  wr_data;
    logic [CFG_W-1:0]  w_clamp;
    logic [CFG_W-1:0]  n_clamp;
    logic              wr_en;
    reg_idx_t          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[2]);
    assign wr_data = pwdata[CFG_W-1:0];

    always_comb
    begin
        if (wr_data == '0)
        begin
            w_clamp = CFG_W'(1);
            n_clamp = CFG_W'(1);
        end
        else
        begin
            w_clamp = (LIM_W'(wr_data) > MAX_W) ? MAX_W[CFG_W-1:0] : wr_data;
            n_clamp = (LIM_W'(wr_data) > MAX_R) ? MAX_R[CFG_W-1:0] : wr_data;
        end
    end

    // An odd pixel count means both factors are odd; dropping the last row
    // is then the same as multiplying by one row fewer.
    assign n_trim    = n_eff_reg - CFG_W'(w_eff_reg[0] & n_eff_reg[0]);
    assign kept_next = KEPT_W'(w_eff_reg) * KEPT_W'(n_trim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= CFG_W'(1);
            rows_reg  <= CFG_W'(1);
            w_eff_reg <= CFG_W'(1);
            n_eff_reg <= CFG_W'(1);
            kept_reg  <= '0;
        end
        else
        begin
            kept_reg <= kept_next;
            if (wr_en)
            begin
                unique case (reg_sel)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg <= wr_data;
                        w_eff_reg <= w_clamp;
                    end
                    REG_IMAGE_ROWS:
                    begin
                        rows_reg  <= wr_data;
                        n_eff_reg <= n_clamp;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_WIDTH: prdata = APB_DW'(width_reg);
            REG_IMAGE_ROWS:  prdata = APB_DW'(rows_reg);
        endcase
    end

    assign cfg.width = w_eff_reg;
    assign cfg.kept  = kept_reg;

endmodule

`default_nettype wire

// File: src/cgag_front.sv
// ----------------------------------------------------------------------------
// cgag_front: pixel intake and classification
// Tracks row, column and position of each pixel, keeps the line buffer and
// the left neighbor, and hands pixels that cause arcs to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cgag_front
    import cgag_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire pixel_t               pixel,
    output logic                      full,
    input  wire cfg_t                 cfg,
    input  wire logic [JOB_CNT_W-1:0] job_count,
    output logic                      job_push,
    output job_t                      job
);

    localparam int LB_DEPTH = (MAX_WIDTH < (1 << COL_W)) ? MAX_WIDTH : (1 << COL_W);
    localparam int LB_AW    = $clog2(LB_DEPTH);
    localparam int SUM_W    = JOB_CNT_W + 1;

    logic [GREY_W-1:0] lb_mem [LB_DEPTH];

    logic              s0_v_reg;
    pixel_t            s0_pix_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              fin_reg;
    logic [GREY_W-1:0] left_reg;

    logic              s1_v_reg;
    logic [GREY_W-1:0] s1_grey_reg;
    logic [GREY_W-1:0] s1_left_reg;
    logic [GREY_W-1:0] s1_up_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_done_reg;

    logic              accept;
    logic [SUM_W-1:0]  pending;
    logic              sop;
    logic [COL_W-1:0]  c_cur;
    logic [ROW_W-1:0]  r_cur;
    logic [POS_W-1:0]  p_cur;
    logic              f_cur;
    logic [POS_W:0]    pos_inc;
    logic              keep;
    logic              done;
    logic              wrap;
    logic [LB_AW-1:0]  lb_addr;

    // Every item in the two intake stages is counted against queue space,
    // so the queue cannot overflow when they arrive.
    assign pending = SUM_W'(job_count) + SUM_W'(s0_v_reg) + SUM_W'(s1_v_reg);
    assign full    = (pending >= SUM_W'(JOB_DEPTH));
    assign accept  = push && !full;

    assign sop     = s0_pix_reg.start_of_image;
    assign c_cur   = sop ? '0 : col_reg;
    assign r_cur   = sop ? '0 : row_reg;
    assign p_cur   = sop ? '0 : pos_reg;
    assign f_cur   = sop ? 1'b0 : fin_reg;
    assign pos_inc = {1'b0, p_cur} + 1'b1;
    assign keep    = s0_v_reg && !f_cur && (KEPT_W'(p_cur) < cfg.kept);
    assign done    = (KEPT_W'(pos_inc) == cfg.kept);
    assign wrap    = ((COL_W+1)'(c_cur) + 1'b1) >= (COL_W+1)'(cfg.width);
    assign lb_addr = c_cur[LB_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
            pos_reg  <= '0;
            fin_reg  <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            s0_v_reg <= accept;
            s1_v_reg <= keep && ((c_cur != '0) || (r_cur != '0));
            if (keep)
            begin
                col_reg  <= wrap ? '0 : c_cur + 1'b1;
                row_reg  <= wrap ? r_cur + 1'b1 : r_cur;
                pos_reg  <= pos_inc[POS_W-1:0];
                fin_reg  <= done;
                left_reg <= s0_pix_reg.grey;
            end
            else if (s0_v_reg)
            begin
                col_reg <= c_cur;
                row_reg <= r_cur;
                pos_reg <= p_cur;
                fin_reg <= f_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_pix_reg <= pixel;
        end
        s1_grey_reg <= s0_pix_reg.grey;
        s1_left_reg <= left_reg;
        s1_row_reg  <= r_cur;
        s1_col_reg  <= c_cur;
        s1_done_reg <= done;
    end

    // Line buffer: the read returns the entry from the previous row before
    // this pixel overwrites it.
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            lb_mem[lb_addr] <= s0_pix_reg.grey;
        end
        s1_up_reg <= lb_mem[lb_addr];
    end

    assign job_push      = s1_v_reg;
    assign job.grey      = s1_grey_reg;
    assign job.left_grey = s1_left_reg;
    assign job.up_grey   = s1_up_reg;
    assign job.row       = s1_row_reg;
    assign job.col       = s1_col_reg;
    assign job.has_left  = (s1_col_reg != '0);
    assign job.has_up    = (s1_row_reg != '0);
    assign job.done      = s1_done_reg;

endmodule

`default_nettype wire

// File: src/cgag_back.sv
// ----------------------------------------------------------------------------
// cgag_back: arc builder
// Turns queued pixels into node numbers and costs; issues one arc per cycle
// while out_full is low, left neighbor first, then upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module cgag_back
    import cgag_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic job_empty,
    input  wire job_t job,
    output logic      job_pop,
    input  wire logic out_full,
    output logic      arc_push,
    output arc_t      arc
);

    // Multiply stage
    logic              m_v_reg;
    job_t              m_job_reg;
    logic [LPOS_W-1:0] m_prod_reg;
    logic [LPOS_W-1:0] m_dleft_reg;
    logic [LPOS_W-1:0] m_dup_reg;

    // Issue stage
    logic              a_v_reg;
    logic [LPOS_W-1:0] a_pos_reg;
    logic [LPOS_W-1:0] a_pl_reg;
    logic [LPOS_W-1:0] a_pu_reg;
    logic [GREY_W-1:0] a_cl_reg;
    logic [GREY_W-1:0] a_cu_reg;
    logic              a_has_left_reg;
    logic              a_has_up_reg;
    logic              a_done_reg;
    logic              a_odd_reg;
    logic              sec_reg;

    logic [NODE_W-1:0] half_p1_reg;

    logic              m_ready;
    logic              a_ready;
    logic              use_up;
    logic              last;
    logic [LPOS_W-1:0] p_nb;
    logic [LPOS_W-1:0] p_even;
    logic [LPOS_W-1:0] p_odd;
    logic [GREY_W-1:0] cost_l;
    logic [GREY_W-1:0] cost_u;

    always_comb
    begin
        cost_l = (m_job_reg.grey > m_job_reg.left_grey) ?
                 m_job_reg.grey - m_job_reg.left_grey : m_job_reg.left_grey - m_job_reg.grey;
        cost_u = (m_job_reg.grey > m_job_reg.up_grey) ?
                 m_job_reg.grey - m_job_reg.up_grey : m_job_reg.up_grey - m_job_reg.grey;
    end

    // The second arc of a pixel is issued after the first has been pushed.
    assign use_up  = sec_reg || !a_has_left_reg;
    assign last    = !(a_has_left_reg && a_has_up_reg && !sec_reg);
    assign p_nb    = use_up ? a_pu_reg : a_pl_reg;
    assign p_even  = a_odd_reg ? p_nb : a_pos_reg;
    assign p_odd   = a_odd_reg ? a_pos_reg : p_nb;

    assign arc_push = a_v_reg && !out_full;
    assign a_ready  = !a_v_reg || (arc_push && last);
    assign m_ready  = !m_v_reg || a_ready;
    assign job_pop  = !job_empty && m_ready;

    assign arc.tail_node  = NODE_W'(1) + p_even[LPOS_W-1:1];
    assign arc.head_node  = half_p1_reg + p_odd[LPOS_W-1:1];
    assign arc.cost       = use_up ? a_cu_reg : a_cl_reg;
    assign arc.last_arc   = last;
    assign arc.image_done = a_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
            a_v_reg <= 1'b0;
            sec_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
            begin
                m_v_reg <= job_pop;
            end
            if (a_ready)
            begin
                a_v_reg <= m_v_reg;
            end
            if (arc_push)
            begin
                sec_reg <= !last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        half_p1_reg <= cfg.kept[KEPT_W-1:1] + 1'b1;
        if (job_pop)
        begin
            m_job_reg   <= job;
            m_prod_reg  <= LPOS_W'(cfg.width) * LPOS_W'(job.row);
            m_dleft_reg <= LPOS_W'(job.col) - 1'b1;
            m_dup_reg   <= LPOS_W'(job.col) - LPOS_W'(cfg.width);
        end
        if (a_ready && m_v_reg)
        begin
            a_pos_reg      <= m_prod_reg + LPOS_W'(m_job_reg.col);
            a_pl_reg       <= m_prod_reg + m_dleft_reg;
            a_pu_reg       <= m_prod_reg + m_dup_reg;
            a_cl_reg       <= cost_l;
            a_cu_reg       <= cost_u;
            a_has_left_reg <= m_job_reg.has_left;
            a_has_up_reg   <= m_job_reg.has_up;
            a_done_reg     <= m_job_reg.done;
            a_odd_reg      <= m_job_reg.row[0] ^ m_job_reg.col[0];
        end
    end

endmodule

`default_nettype wire

// File: src/checkerboard_grid_arc_generator.sv
// ----------------------------------------------------------------------------
// checkerboard_grid_arc_generator: grid graph arcs from a raster pixel stream
// Pixels enter on a push/full port, weighted arcs leave on an empty/pop port.
// Geometry is set through the APB register port (width at 0x0, rows at 0x4).
//
// Each kept pixel gives an arc to its left neighbor and then one to its upper
// neighbor; pixels in the first row or column give fewer, and pixels beyond
// the kept count give none. A pixel marked start_of_image restarts at (0,0).
// The intake takes one pixel per cycle while full is low. The arc builder
// issues one arc per cycle while the result queue has room; an interior
// pixel gives two arcs, and the eight-entry job queue absorbs short bursts.
// A pixel's first arc passes the intake stages, the job queue, the
// multiply and issue stages and the result queue before it is visible.
// A stalled result port fills the two-entry result queue, then the builder,
// then the job queue, after which full is raised. Reset empties all queues,
// sets width and rows to 1 and clears the position counters; the line
// buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module checkerboard_grid_arc_generator
    import cgag_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_ROWS  = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic              push,
    output logic                   full,
    input  wire pixel_t            pixel,
    output logic                   empty,
    input  wire logic              pop,
    output arc_t                   arc
);

    cfg_t                 cfg;
    logic                 job_push;
    job_t                 job_in;
    logic                 job_full;
    logic                 job_pop;
    job_t                 job_out;
    logic                 job_empty;
    logic [JOB_CNT_W-1:0] job_count;
    logic                 arc_push;
    arc_t                 arc_in;
    logic                 arc_full;

    cgag_regs #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cgag_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pixel     (pixel),
        .full      (full),
        .cfg       (cfg),
        .job_count (job_count),
        .job_push  (job_push),
        .job       (job_in)
    );

    cgag_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_out),
        .empty (job_empty),
        .count (job_count)
    );

    cgag_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .out_full  (arc_full),
        .arc_push  (arc_push),
        .arc       (arc_in)
    );

    cgag_fifo #(
        .WIDTH ($bits(arc_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (arc_push),
        .wdata (arc_in),
        .full  (arc_full),
        .pop   (pop),
        .rdata (arc),
        .empty (empty),
        .count ()
    );

    // The intake reserves queue space for items in flight.
    assert property (@(posedge clk) disable iff (!rst_n) !(job_push && job_full))
        else $error("job queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n) !(job_pop && job_empty))
        else $error("job queue read while empty");

    // The kept pixel count is always even after trimming.
    assert property (@(posedge clk) disable iff (!rst_n) cfg.kept[0] == 1'b0)
        else $error("kept pixel count is odd");

endmodule

`default_nettype wire

// File: verif/cgag_arc_checker.sv
// ----------------------------------------------------------------------------
// cgag_arc_checker: arc predictor and scoreboard for the grid arc generator
// Follows register writes and accepted pixels, predicts the arcs that each
// pixel causes, and compares every popped arc field by field with the oldest
// prediction. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module cgag_arc_checker
    import cgag_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    input  wire logic              pready,
    input  wire logic              push,
    input  wire logic              full,
    input  wire pixel_t            pixel,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire arc_t              arc,
    output int                     fail_count,
    output int                     arcs_waiting
);

    localparam longint unsigned MAX_COLS  = 4096;
    localparam longint unsigned MAX_LINES = 4096;
    localparam longint unsigned NODE_MASK = (64'd1 << NODE_W) - 1;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  rows_reg;
    logic [GREY_W-1:0] line_buf [MAX_COLS];
    logic [GREY_W-1:0] left_grey;
    logic [ROW_W-1:0]  row_idx;
    int unsigned       col_idx;
    logic [POS_W-1:0]  pos_cnt;
    logic              image_finished;
    arc_t              pending_arcs [$];

    initial fail_count = 0;

    // Zero means one; anything above the buffer size saturates.
    function automatic longint unsigned clamp_dim(input longint unsigned v,
                                                  input longint unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint unsigned node_number(input longint unsigned r,
                                                    input longint unsigned c,
                                                    input longint unsigned w,
                                                    input longint unsigned half);
        longint unsigned grid_pos;
        longint unsigned base;
        grid_pos = w * r + c;
        base = (((r + c) & 1) != 0) ? half + 1 : 1;
        return (base + grid_pos / 2) & NODE_MASK;
    endfunction

    // The even-parity endpoint is always the tail.
    function automatic arc_t make_arc(input longint unsigned me,
                                      input longint unsigned other,
                                      input bit me_odd,
                                      input logic [GREY_W-1:0] ga,
                                      input logic [GREY_W-1:0] gb);
        arc_t a;
        a.tail_node  = NODE_W'(me_odd ? other : me);
        a.head_node  = NODE_W'(me_odd ? me : other);
        a.cost       = (ga > gb) ? ga - gb : gb - ga;
        a.last_arc   = 1'b0;
        a.image_done = 1'b0;
        return a;
    endfunction

    task automatic predict_arcs(input pixel_t px);
        longint unsigned w;
        longint unsigned kept;
        longint unsigned half;
        longint unsigned r;
        longint unsigned c;
        longint unsigned me;
        bit              me_odd;
        bit              last_pixel;
        arc_t            found [$];
        w = clamp_dim(width_reg, MAX_COLS);
        kept = w * clamp_dim(rows_reg, MAX_LINES);
        if (kept[0])
            kept = kept - w;
        half = kept / 2;
        if (px.start_of_image)
        begin
            row_idx = '0;
            col_idx = 0;
            pos_cnt = '0;
            image_finished = 1'b0;
        end
        if (image_finished || pos_cnt >= kept)
            return;
        r = row_idx;
        c = col_idx;
        me_odd = ((r + c) & 1) != 0;
        me = node_number(r, c, w, half);
        last_pixel = (pos_cnt + 1 == kept);
        if (c > 0)
            found.push_back(make_arc(me, node_number(r, c - 1, w, half), me_odd,
                                     px.grey, left_grey));
        if (r > 0)
            found.push_back(make_arc(me, node_number(r - 1, c, w, half), me_odd,
                                     px.grey, line_buf[c]));
        foreach (found[i])
        begin
            found[i].image_done = last_pixel;
            found[i].last_arc = (i == found.size() - 1);
            pending_arcs.push_back(found[i]);
        end
        left_grey = px.grey;
        line_buf[c] = px.grey;
        if (c + 1 >= w)
        begin
            col_idx = 0;
            row_idx = row_idx + 1'b1;
        end
        else
            col_idx = 32'(c + 1);
        pos_cnt = pos_cnt + 1'b1;
        if (last_pixel)
            image_finished = 1'b1;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            fail_count++;
            $display("%0t: arc %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    task automatic check_arc(input arc_t got);
        arc_t want;
        if (pending_arcs.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected arc, expected none, got tail %0d head %0d cost %0d",
                     $time, got.tail_node, got.head_node, got.cost);
            return;
        end
        want = pending_arcs.pop_front();
        compare_field("tail_node", want.tail_node, got.tail_node);
        compare_field("head_node", want.head_node, got.head_node);
        compare_field("cost", want.cost, got.cost);
        compare_field("last_arc", want.last_arc, got.last_arc);
        compare_field("image_done", want.image_done, got.image_done);
    endtask

    // Within one edge the write, the pop and then the push are handled; the
    // block never returns an arc in the cycle its pixel is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = 1;
            rows_reg = 1;
            left_grey = '0;
            row_idx = '0;
            col_idx = 0;
            pos_cnt = '0;
            image_finished = 1'b0;
            pending_arcs.delete();
            arcs_waiting = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (reg_idx_t'(paddr[2]) == REG_IMAGE_WIDTH)
                    width_reg = pwdata[CFG_W-1:0];
                else
                    rows_reg = pwdata[CFG_W-1:0];
            end
            if (pop && !empty)
                check_arc(arc);
            if (push && !full)
                predict_arcs(pixel);
            arcs_waiting = pending_arcs.size();
        end
    end

endmodule

// File: verif/checkerboard_grid_arc_generator_test.sv
// ----------------------------------------------------------------------------
// checkerboard_grid_arc_generator_test: top of the grid arc generator bench
// Programs image geometry over APB, streams directed and random pixel images
// with random gaps on both sides and one long result stall, and reports the
// verdict from the failure count and the arcs still waiting in the checker.
// ----------------------------------------------------------------------------
module checkerboard_grid_arc_generator_test;
    import cgag_pkg::*;

    localparam int RANDOM_PIXELS  = 1400;
    localparam int QUIET_FROM     = 1200;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              push = 1'b0;
    logic              full;
    pixel_t            pixel = '0;
    logic              empty;
    logic              pop = 1'b0;
    arc_t              arc;
    int                fail_count;
    int                arcs_waiting;
    int                stall_cycles = 0;
    int                random_pixels = 0;
    bit                push_idle = 1'b0;
    bit                pop_idle = 1'b0;
    bit                quiet = 1'b0;
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;

    always #2 clk = ~clk;

    checkerboard_grid_arc_generator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .pixel   (pixel),
        .empty   (empty),
        .pop     (pop),
        .arc     (arc)
    );

    cgag_arc_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .pixel        (pixel),
        .empty        (empty),
        .pop          (pop),
        .arc          (arc),
        .fail_count   (fail_count),
        .arcs_waiting (arcs_waiting)
    );

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {19'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [GREY_W-1:0] grey_level, input logic sof);
        if (push_idle && !quiet && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        push <= 1'b1;
        pixel <= '{grey_level, sof};
        do @(posedge clk); while (full);
    endtask

    function automatic logic [GREY_W-1:0] random_grey();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return GREY_W'($urandom_range(0, 255));
        endcase
    endfunction

    // A run of random pixels; the first one may carry the start mark.
    task automatic send_run(input int unsigned count, input bit with_start);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(random_grey(), with_start && i == 0);
    endtask

    // Waits until every predicted arc has been popped, then gives the block
    // time to finish pixels that cause no arc.
    task automatic settle();
        push <= 1'b0;
        do @(negedge clk); while (arcs_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int unsigned eff_dim(input int unsigned v);
        if (v == 0)
            return 1;
        if (v > 4096)
            return 4096;
        return v;
    endfunction

    // Result side: random stalls, one long hold-off, none at the end.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (pop_idle && !quiet && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int unsigned cols;
        int unsigned lines;
        int unsigned total;
        int unsigned count;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Without a start mark after reset the first pixel is still (0,0).
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_ROWS, 2);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd9, 1'b0);
        // A start mark in the middle of an image restarts it.
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd13, 1'b0);
        send_pixel(8'd77, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd170, 1'b1);
        settle();

        // Odd pixel count: the third row is dropped.
        write_reg(REG_IMAGE_ROWS, 3);
        send_run(9, 1'b1);
        settle();

        // Zero registers act as one, and a single odd pixel keeps nothing.
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_ROWS, 0);
        send_pixel(8'd5, 1'b1);
        send_pixel(8'd6, 1'b0);
        settle();

        // Row count changed in the middle of an image.
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_ROWS, 4);
        send_run(6, 1'b1);
        settle();
        write_reg(REG_IMAGE_ROWS, 2);
        send_run(4, 1'b0);
        settle();

        // Saturated geometry, only the start of the image is sent. The result
        // side holds off meanwhile, so the block fills and stalls its input.
        write_reg(REG_IMAGE_WIDTH, 8191);
        write_reg(REG_IMAGE_ROWS, 8191);
        hold_req = 1'b1;
        send_run(300, 1'b1);
        settle();
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_ROWS, 4096);
        send_run(30, 1'b1);

        while (random_pixels < RANDOM_PIXELS)
        begin
            settle();
            case ($urandom_range(0, 19))
                0: cols = 0;
                1: cols = $urandom_range(13, 80);
                default: cols = $urandom_range(1, 12);
            endcase
            lines = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            write_reg(REG_IMAGE_WIDTH, CFG_W'(cols));
            write_reg(REG_IMAGE_ROWS, CFG_W'(lines));
            push_idle = $urandom_range(0, 3) != 0;
            pop_idle = $urandom_range(0, 3) != 0;
            if (random_pixels >= QUIET_FROM)
                quiet = 1'b1;
            total = eff_dim(cols) * eff_dim(lines);
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        // Up to a whole image; a short run leaves the next start mark to restart mid-image.
                        count = $urandom_range(1, total);
                        send_run(count, 1'b1);
                        random_pixels += count;
                    end
                    1:
                    begin
                        repeat ($urandom_range(1, 4))
                            send_pixel(random_grey(), 1'($urandom_range(0, 1)));
                    end
                    default:
                    begin
                        send_run(total, 1'b1);
                        send_run($urandom_range(0, 2), 1'b0);
                        random_pixels += total;
                    end
                endcase
            end
        end

        settle();
        if (fail_count == 0 && arcs_waiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
